// ===== sv/prga_pkg.sv =====
// Shared codes and widths for the paired resource grant arbiter.
package prga_pkg;

	localparam int ID_W = 5;

	localparam logic ACT_REQUEST = 1'b0;
	localparam logic ACT_RELEASE = 1'b1;

	localparam logic KIND_GRANT = 1'b0;
	localparam logic KIND_DONE  = 1'b1;

	localparam int GRANT_CNT_W = 4;
	localparam logic [GRANT_CNT_W-1:0] MAX_GRANTS = 4'd8;

	localparam logic [ID_W-1:0] CFG_RESET_N = 5'd5;

endpackage

// ===== sv/prga_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module prga_ram #(
	parameter int WIDTH = 5,
	parameter int DEPTH = 16,
	localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [AddrW-1:0]         waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [AddrW-1:0]         raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== sv/paired_resource_grant_arbiter_core.sv =====
// Top level: ring waiter granting paired resources, with a RAM-held FIFO wait list.
//
// A request gives at most one grant beat. A release scans the wait list, which
// lives in a RAM with one read port: the scan reads one entry per cycle,
// compacts survivors back in place and emits every grant it finds, up to
// eight per release, followed by a single all-done beat once every requester in
// the ring has released. A stalled output pauses the scan. After the all-done
// beat, items are still taken but ignored until reset; the ring size register
// resets to 5.
module paired_resource_grant_arbiter_core
	import prga_pkg::*;
#(
	parameter int MAX_REQUESTERS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [ID_W-1:0] cfg_data,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic            action,
	input  logic [ID_W-1:0] requester,
	output logic            out_valid,
	input  logic            out_ready,
	output logic            kind,
	output logic [ID_W-1:0] target,
	output logic            last
);
	localparam int AW = (MAX_REQUESTERS > 1) ? $clog2(MAX_REQUESTERS) : 1;
	localparam int CW = $clog2(MAX_REQUESTERS + 1);
	localparam int VW = (CW > ID_W) ? CW : ID_W;
	localparam int SW = 2;

	localparam logic [SW-1:0] ST_IDLE  = 2'd0;
	localparam logic [SW-1:0] ST_SCAN  = 2'd1;
	localparam logic [SW-1:0] ST_FIN   = 2'd2;
	localparam logic [SW-1:0] ST_FLUSH = 2'd3;

	logic [SW-1:0]             state_q;
	logic [ID_W-1:0]           num_q;
	logic [MAX_REQUESTERS-1:0] free_q, served_q, waiting_q;
	logic [CW-1:0]             count_q, i_q, j_q;
	logic [GRANT_CNT_W-1:0]    k_q;
	logic                      finished_q;
	logic                      pend_v_q, pend_kind_q;
	logic [ID_W-1:0]           pend_target_q;
	logic                      out_valid_q, kind_q, last_q;
	logic [ID_W-1:0]           target_q;

	logic [CW-1:0]             ring_n;
	logic [MAX_REQUESTERS-1:0] need, wneed, ring_mask;
	logic [ID_W-1:0]           w;
	logic                      out_free, in_fire, p_ok, w_ok, w_fit, dup, free_ok;
	logic                      scan_grant, scan_stall, advance, all_served, fin_stall;
	logic                      ram_we;
	logic [AW-1:0]             ram_waddr, ram_raddr;
	logic [ID_W-1:0]           ram_wdata;
	logic                      push, push_kind, push_last;
	logic [ID_W-1:0]           push_target;
	logic [CW-1:0]             i_next;

	function automatic logic [MAX_REQUESTERS-1:0] pair_bits(
		input logic [ID_W-1:0] p,
		input logic [CW-1:0]   n
	);
		logic [AW-1:0] a, b;
		a = AW'(p - 1'b1);
		b = (VW'(p) == VW'(n)) ? '0 : AW'(p);
		return (MAX_REQUESTERS'(1) << a) | (MAX_REQUESTERS'(1) << b);
	endfunction

	always_comb begin
		if (num_q == '0) begin
			ring_n = CW'(1);
		end else if (VW'(num_q) > VW'(MAX_REQUESTERS)) begin
			ring_n = CW'(MAX_REQUESTERS);
		end else begin
			ring_n = CW'(num_q);
		end
	end

	always_comb begin
		for (int b = 0; b < MAX_REQUESTERS; b++) begin
			ring_mask[b] = (b < int'(ring_n));
		end
	end

	prga_ram #(
		.WIDTH(ID_W),
		.DEPTH(MAX_REQUESTERS)
	) u_wait_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(w)
	);

	assign out_free   = !out_valid_q || out_ready;
	assign in_ready   = (state_q == ST_IDLE) && out_free;
	assign in_fire    = in_valid && in_ready;
	assign p_ok       = (requester != '0) && (VW'(requester) <= VW'(ring_n));
	assign need       = pair_bits(requester, ring_n);
	assign dup        = waiting_q[AW'(requester - 1'b1)];
	assign free_ok    = (free_q & need) == need;

	assign w_ok       = (w != '0) && (VW'(w) <= VW'(ring_n));
	assign wneed      = pair_bits(w, ring_n);
	assign w_fit      = ((free_q & wneed) == wneed) && (k_q < MAX_GRANTS);
	assign scan_grant = (state_q == ST_SCAN) && w_ok && w_fit;
	assign scan_stall = scan_grant && pend_v_q && !out_free;
	assign advance    = (state_q == ST_SCAN) && !scan_stall;
	assign i_next     = i_q + 1'b1;

	assign all_served = (served_q & ring_mask) == ring_mask;
	assign fin_stall  = all_served && pend_v_q && !out_free;

	always_comb begin
		ram_raddr = '0;
		if (state_q == ST_SCAN) begin
			ram_raddr = advance ? AW'(i_next) : AW'(i_q);
		end
		ram_we    = 1'b0;
		ram_waddr = AW'(count_q);
		ram_wdata = requester;
		if (advance && w_ok && !w_fit) begin
			ram_we    = 1'b1;
			ram_waddr = AW'(j_q);
			ram_wdata = w;
		end else if (in_fire && !finished_q && p_ok && action == ACT_REQUEST && !dup
				&& !free_ok && count_q < CW'(MAX_REQUESTERS)) begin
			ram_we = 1'b1;
		end
	end

	always_comb begin
		push        = 1'b0;
		push_kind   = pend_kind_q;
		push_target = pend_target_q;
		push_last   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_fire && !finished_q && p_ok && action == ACT_REQUEST && !dup
						&& free_ok) begin
					push        = 1'b1;
					push_kind   = KIND_GRANT;
					push_target = requester;
					push_last   = 1'b1;
				end
			end
			ST_SCAN:  push = scan_grant && !scan_stall && pend_v_q;
			ST_FIN:   push = all_served && !fin_stall && pend_v_q;
			ST_FLUSH: begin
				push      = pend_v_q && out_free;
				push_last = 1'b1;
			end
			default: push = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q <= CFG_RESET_N;
		end else if (cfg_we) begin
			num_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			kind_q   <= push_kind;
			target_q <= push_target;
			last_q   <= push_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			free_q     <= '1;
			served_q   <= '0;
			waiting_q  <= '0;
			count_q    <= '0;
			i_q        <= '0;
			j_q        <= '0;
			k_q        <= '0;
			finished_q <= 1'b0;
			pend_v_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire && !finished_q && p_ok) begin
						if (action == ACT_RELEASE) begin
							free_q   <= free_q | need;
							served_q <= served_q | (MAX_REQUESTERS'(1) << AW'(requester - 1'b1));
							i_q      <= '0;
							j_q      <= '0;
							k_q      <= '0;
							state_q  <= (count_q == '0) ? ST_FIN : ST_SCAN;
						end else if (!dup && free_ok) begin
							free_q <= free_q & ~need;
						end else if (!dup && count_q < CW'(MAX_REQUESTERS)) begin
							waiting_q[AW'(requester - 1'b1)] <= 1'b1;
							count_q <= count_q + 1'b1;
						end
					end
				end
				ST_SCAN: begin
					if (advance) begin
						if (w_ok && w_fit) begin
							free_q                   <= free_q & ~wneed;
							waiting_q[AW'(w - 1'b1)] <= 1'b0;
							k_q                      <= k_q + 1'b1;
							pend_v_q                 <= 1'b1;
						end else if (!w_ok) begin
							waiting_q[AW'(w - 1'b1)] <= 1'b0;
						end else begin
							j_q <= j_q + 1'b1;
						end
						i_q <= i_next;
						if (i_next == count_q) begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_FIN: begin
					count_q <= j_q;
					if (!fin_stall) begin
						if (all_served) begin
							finished_q <= 1'b1;
							pend_v_q   <= 1'b1;
						end
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					if (!pend_v_q || out_free) begin
						pend_v_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (scan_grant && !scan_stall) begin
			pend_kind_q   <= KIND_GRANT;
			pend_target_q <= w;
		end else if (state_q == ST_FIN && all_served && !fin_stall) begin
			pend_kind_q   <= KIND_DONE;
			pend_target_q <= '0;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign target    = target_q;
	assign last      = last_q;
endmodule

// ===== sv/prga_chk.sv =====
// Port-level checker for the arbiter core, bound to the top level.
module prga_chk
	import prga_pkg::*;
(
	input logic            clk,
	input logic            arst_n,
	input logic            in_ready,
	input logic            out_valid,
	input logic            out_ready,
	input logic            kind,
	input logic [ID_W-1:0] target,
	input logic            last
);
	a_done_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_DONE |-> last && target == '0)
		else $error("all-done beat must be last with target zero");

	a_grant_target: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_GRANT |-> target != '0)
		else $error("grant beat names no requester");

	a_done_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && kind == KIND_DONE |=> !out_valid)
		else $error("beat after all-done");

	a_in_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid || out_ready)
		else $error("input taken while output blocked");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(target) && $stable(kind)
			&& $stable(last))
		else $error("stalled output beat changed");
endmodule

bind paired_resource_grant_arbiter_core prga_chk u_prga_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.kind     (kind),
	.target   (target),
	.last     (last)
);
